/* hdl/bvcl_pkg.sv */
// shared types, widths and reset constants for the battery charge level block
package bvcl_pkg;

  // field and register widths
  localparam int MAX_POINTS = 6;
  localparam int PIN_W      = 12;
  localparam int MV_W       = 16;
  localparam int PPTT_W     = 16;
  localparam int LVL_W      = 14;
  localparam int OHM_W      = 24;
  localparam int PT_W       = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // serial arithmetic widths
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int QUO_W   = 16;

  // register indexes past the curve points
  localparam logic [CFG_IDX_W-1:0] REG_DIV_TOTAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_LEG   = 3'd7;

  // reset values
  localparam logic [PT_W-1:0] CURVE_RESET [MAX_POINTS] = '{
    32'd275261200, 32'd258875200, 32'd252319600,
    32'd245764000, 32'd239208400, 32'd216268800
  };
  localparam logic [OHM_W-1:0] DIV_TOTAL_RESET = 24'd1500000;
  localparam logic [OHM_W-1:0] DIV_LEG_RESET   = 24'd180000;

  localparam logic [MV_W-1:0]  MV_SAT  = 16'hFFFF;
  localparam logic [LVL_W-1:0] LVL_SAT = 14'h3FFF;

  // multiplier request and response
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] mcand;
    logic [MUL_B_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [OHM_W-1:0] divisor;
    logic [OHM_W-1:0] rem_init;
    logic [QUO_W-1:0] low;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

/* hdl/bvcl_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
module bvcl_mul (
  input  logic                clk,
  input  logic                rst,
  input  bvcl_pkg::mul_req_t  req,
  output bvcl_pkg::mul_rsp_t  rsp
);
  import bvcl_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W + 1);

  logic [PROD_W-1:0]  acc;
  logic [MUL_A_W-1:0] mc;
  logic [CNT_W-1:0]   cnt;
  logic               done;
  logic [MUL_A_W:0]   part;

  // add the multiplicand into the upper half when the low bit is set
  assign part = {1'b0, acc[PROD_W-1:MUL_B_W]} + (acc[0] ? {1'b0, mc} : '0);

  // accumulator shifts right one bit per step
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      acc  <= {{MUL_A_W{1'b0}}, req.mplier};
      mc   <= req.mcand;
      cnt  <= CNT_W'(MUL_B_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      acc <= {part, acc[MUL_B_W-1:1]};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

/* hdl/bvcl_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module bvcl_div (
  input  logic                clk,
  input  logic                rst,
  input  bvcl_pkg::div_req_t  req,
  output bvcl_pkg::div_rsp_t  rsp
);
  import bvcl_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [OHM_W-1:0] rem;
  logic [OHM_W-1:0] dvs;
  logic [QUO_W-1:0] q;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [OHM_W:0]   trial;
  logic             ge;
  logic [OHM_W:0]   diff;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {rem, q[QUO_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  // remainder and quotient shift left together
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      rem  <= req.rem_init;
      dvs  <= req.divisor;
      q    <= req.low;
      cnt  <= CNT_W'(QUO_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      rem <= ge ? diff[OHM_W-1:0] : trial[OHM_W-1:0];
      q   <= {q[QUO_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = q;

endmodule

/* hdl/battery_voltage_to_charge_level.sv */
// top level: battery voltage scaling and charge level lookup
//
// Input channel (in_valid/in_ready, pin_millivolts) takes one word per
// conversion. Output channel (out_valid/out_ready) returns the battery
// voltage in millivolts, saturated at 65535, and the charge level in
// hundredths of a percent. Config channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes curve points 0..NPTS-1 and the two divider
// resistances; cfg_ready is always high. The user must make writes only
// while idle; the block itself does not enforce this. One word is worked
// at a time. The pin voltage goes through a bit-serial multiply and, unless
// the quotient would saturate, a bit-serial divide, then a walk down the
// curve of one point per cycle, then, when the voltage falls between two
// points, another bit-serial multiply and divide. The next word is
// taken at the earliest in the cycle after the result is loaded into
// the output register.
// A finished word waits in the output register while out_ready is low;
// the next input word is taken meanwhile and held at the end of its
// work until the output register frees. Synchronous reset clears the
// control state and loads the default curve and divider values.
module battery_voltage_to_charge_level #(
  parameter int CURVE_POINTS = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bvcl_pkg::PIN_W-1:0]       pin_millivolts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bvcl_pkg::MV_W-1:0]        battery_millivolts,
  output logic [bvcl_pkg::LVL_W-1:0]       level_pptt,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bvcl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bvcl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bvcl_pkg::*;

  localparam int NPTS  = (CURVE_POINTS < 2) ? 2 :
                         (CURVE_POINTS > MAX_POINTS) ? MAX_POINTS : CURVE_POINTS;
  localparam int IDX_W = $clog2(NPTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NPTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_DIV1, S_WALK, S_MUL2, S_DIV2, S_DONE
  } state_t;

  state_t           state;
  logic [PT_W-1:0]  curve [NPTS];
  logic [OHM_W-1:0] div_total;
  logic [OHM_W-1:0] div_leg;
  logic [IDX_W-1:0] idx;
  logic [MV_W-1:0]  mv;
  logic [PT_W-1:0]  prev;
  logic [PPTT_W-1:0] lo_p;
  logic             neg;
  logic [MV_W-1:0]  den;
  logic [LVL_W-1:0] lvl;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [PT_W-1:0]   pt;
  logic [MV_W-1:0]   pt_mv;
  logic [PPTT_W-1:0] pt_p;
  logic [MV_W-1:0]   prev_mv;
  logic [PPTT_W-1:0] prev_p;
  logic              stop;
  logic              direct;
  logic              neg_w;
  logic [PPTT_W-1:0] mag;
  logic [MV_W-1:0]   dv;
  logic              sat;
  logic [PPTT_W:0]   lvl_raw;
  logic              out_free;
  logic              out_load;

  // saturate a nonnegative level to the output field
  function automatic logic [LVL_W-1:0] sat_level(input logic [PPTT_W:0] v);
    logic [LVL_W-1:0] r;
    r = (v > {{(PPTT_W + 1 - LVL_W){1'b0}}, LVL_SAT}) ? LVL_SAT : v[LVL_W-1:0];
    return r;
  endfunction

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NPTS; i++) begin
        curve[i] <= CURVE_RESET[i];
      end
      div_total <= DIV_TOTAL_RESET;
      div_leg   <= DIV_LEG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index < CFG_IDX_W'(NPTS)) begin
        curve[cfg_index[IDX_W-1:0]] <= cfg_data;
      end else if (cfg_index == REG_DIV_TOTAL) begin
        div_total <= cfg_data[OHM_W-1:0];
      end else if (cfg_index == REG_DIV_LEG) begin
        div_leg <= cfg_data[OHM_W-1:0];
      end
    end
  end

  // current and previous curve point during the walk
  assign pt      = curve[idx];
  assign pt_mv   = pt[PT_W-1:PPTT_W];
  assign pt_p    = pt[PPTT_W-1:0];
  assign prev_mv = prev[PT_W-1:PPTT_W];
  assign prev_p  = prev[PPTT_W-1:0];
  assign stop    = (idx == LAST_IDX) || (pt_p == '0) || (mv >= pt_mv);
  assign direct  = (mv < pt_mv) || (idx == '0);
  assign neg_w   = prev_p < pt_p;
  assign mag     = neg_w ? (pt_p - prev_p) : (prev_p - pt_p);
  assign dv      = mv - pt_mv;

  // quotient would pass 16 bits, or divisor is zero
  assign sat = mul_rsp.prod[PROD_W-1:QUO_W] >= div_leg;

  // final level from the interpolation quotient
  always_comb begin
    if (neg) begin
      lvl_raw = (lo_p >= div_rsp.quo) ? {1'b0, lo_p - div_rsp.quo} : '0;
    end else begin
      lvl_raw = {1'b0, lo_p} + {1'b0, div_rsp.quo};
    end
  end

  // operand selection for the shared serial units
  always_comb begin
    mul_req.start  = ((state == S_IDLE) && in_valid) ||
                     ((state == S_WALK) && stop && !direct);
    mul_req.mcand  = (state == S_IDLE) ? div_total : {{(MUL_A_W - PPTT_W){1'b0}}, mag};
    mul_req.mplier = (state == S_IDLE) ? {{(MUL_B_W - PIN_W){1'b0}}, pin_millivolts} : dv;
    div_req.start  = ((state == S_MUL1) && mul_rsp.done && !sat) ||
                     ((state == S_MUL2) && mul_rsp.done);
    div_req.divisor  = (state == S_MUL1) ? div_leg : {{(OHM_W - MV_W){1'b0}}, den};
    div_req.rem_init = mul_rsp.prod[PROD_W-1:QUO_W];
    div_req.low      = mul_rsp.prod[QUO_W-1:0];
  end

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_DONE) && out_free;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mul_rsp.done) begin
            if (sat) begin
              mv    <= MV_SAT;
              idx   <= '0;
              state <= S_WALK;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            mv    <= div_rsp.quo;
            idx   <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (!stop) begin
            prev <= pt;
            idx  <= idx + IDX_W'(1);
          end else if (direct) begin
            lvl   <= sat_level({1'b0, pt_p});
            state <= S_DONE;
          end else begin
            lo_p  <= pt_p;
            neg   <= neg_w;
            den   <= prev_mv - pt_mv;
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_rsp.done) begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            lvl   <= sat_level(lvl_raw);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            battery_millivolts <= mv;
            level_pptt         <= lvl;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // serial arithmetic units
  bvcl_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  bvcl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

/* hdl/bvcl_check.sv */
// port-level checks for the battery charge level block, bound to the top level
module bvcl_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [bvcl_pkg::MV_W-1:0]        battery_millivolts,
  input logic [bvcl_pkg::LVL_W-1:0]       level_pptt
);
  import bvcl_pkg::*;

  logic [1:0] pending;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // words taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(battery_millivolts) &&
    $stable(level_pptt))
    else $error("output word changed while stalled");

  // no output word without a word taken in
  a_out_has_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("output word with no input outstanding");

  // at most one word in work and one waiting at the output
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !in_ready)
    else $error("input taken with two words outstanding");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind battery_voltage_to_charge_level bvcl_check u_bvcl_check (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .battery_millivolts (battery_millivolts),
  .level_pptt         (level_pptt)
);

/* bench/testbench.sv */
// testbench for the battery voltage to charge level block
`timescale 1ns / 1ps

module testbench;
  import bvcl_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int NUM_POINTS  = 6;
  localparam int SETTLE      = 80;
  localparam int END_WAIT    = 100;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_0 = 3'd0;

  // one charge word as the output channel carries it
  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [LVL_W-1:0] level;
  } charge_word_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIN_W-1:0]      pin_millivolts;
  logic                  out_valid;
  logic                  out_ready;
  logic [MV_W-1:0]       battery_millivolts;
  logic [LVL_W-1:0]      level_pptt;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the register file
  logic [PT_W-1:0]  curve_pt [MAX_POINTS];
  logic [OHM_W-1:0] div_total;
  logic [OHM_W-1:0] div_leg;

  charge_word_t charge_expected [$];

  int  words_sent    = 0;
  int  words_checked = 0;
  int  cfg_writes    = 0;
  int  errors        = 0;
  int  random_curves = 0;
  bit  idle_on       = 1'b0;
  int  hold_requests = 0;
  int  hold_served   = 0;
  int  hold_left     = 0;
  int  stall_left    = 0;

  battery_voltage_to_charge_level #(
    .CURVE_POINTS(NUM_POINTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pin_millivolts(pin_millivolts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .battery_millivolts(battery_millivolts),
    .level_pptt(level_pptt),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // expected battery voltage and charge level for one pin reading
  function automatic charge_word_t predict_charge(input logic [PIN_W-1:0] pin);
    charge_word_t   w;
    longint unsigned scaled;
    longint         mv;
    longint         raw;
    longint         den;
    longint         pv [MAX_POINTS];
    longint         pp [MAX_POINTS];
    int             n;
    int             i;
    n = NUM_POINTS < 2 ? 2 : (NUM_POINTS > MAX_POINTS ? MAX_POINTS : NUM_POINTS);
    if (div_leg == '0) begin
      scaled = MV_SAT;
    end else begin
      scaled = (64'(pin) * 64'(div_total)) / 64'(div_leg);
      if (scaled > MV_SAT) begin
        scaled = MV_SAT;
      end
    end
    mv = longint'(scaled);
    for (i = 0; i < MAX_POINTS; i++) begin
      pv[i] = curve_pt[i][PT_W-1:PPTT_W];
      pp[i] = curve_pt[i][PPTT_W-1:0];
    end
    // at or above the top point the top charge holds
    if (mv >= pv[0]) begin
      raw = pp[0];
    end else begin
      // walk down until a zero charge, a point at or below mv, or the last point
      i = 0;
      while (i + 1 < n && pp[i] > 0 && mv < pv[i]) i++;
      if (mv < pv[i] || i == 0) begin
        raw = pp[i];
      end else begin
        den = pv[i-1] - pv[i];
        if (den <= 0) begin
          raw = pp[i];
        end else begin
          raw = pp[i] + ((pp[i-1] - pp[i]) * (mv - pv[i])) / den;
        end
      end
    end
    w.mv = scaled[MV_W-1:0];
    if (raw < 0) begin
      w.level = '0;
    end else if (raw > longint'(LVL_SAT)) begin
      w.level = LVL_SAT;
    end else begin
      w.level = raw[LVL_W-1:0];
    end
    return w;
  endfunction

  // send one pin word, with an optional gap before it
  task automatic send_pin(input logic [PIN_W-1:0] pin);
    charge_word_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid       = 1'b1;
    pin_millivolts = pin;
    want           = predict_charge(pin);
    do @(posedge clk); while (!in_ready);
    charge_expected.push_back(want);
    words_sent++;
    @(negedge clk);
  endtask

  // one register write, mirrored into the predictor on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < MAX_POINTS) begin
      curve_pt[idx] = data;
    end else if (idx == REG_DIV_TOTAL) begin
      div_total = data[OHM_W-1:0];
    end else if (idx == REG_DIV_LEG) begin
      div_leg = data[OHM_W-1:0];
    end
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // all six curve points, point 0 in the top bits
  task automatic load_curve(input logic [PT_W*MAX_POINTS-1:0] pts);
    int k;
    for (k = 0; k < MAX_POINTS; k++) begin
      write_reg(REG_CURVE_0 + CFG_IDX_W'(k), pts[PT_W*(MAX_POINTS-1-k) +: PT_W]);
    end
  endtask

  task automatic load_divider(input logic [OHM_W-1:0] full, input logic [OHM_W-1:0] outr);
    write_reg(REG_DIV_TOTAL, CFG_DATA_W'(full));
    write_reg(REG_DIV_LEG, CFG_DATA_W'(outr));
  endtask

  // stop sending and wait for every expected word, then let the block settle
  task automatic wait_for_results(input int extra);
    int waited;
    waited   = 0;
    in_valid = 1'b0;
    while (charge_expected.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // reset curve: every point, the neighbors of the top and bottom points and both pin extremes
  task automatic test_reset_curve;
    send_pin(12'd0);
    send_pin(12'd4095);
    send_pin(12'd504);
    send_pin(12'd503);
    send_pin(12'd474);
    send_pin(12'd462);
    send_pin(12'd450);
    send_pin(12'd438);
    send_pin(12'd396);
    send_pin(12'd395);
    wait_for_results(SETTLE);
  endtask

  // unit ratio, zero output leg, all-ones top point, saturating and vanishing ratios
  task automatic test_divider_corners;
    load_divider(24'd1, 24'd1);
    send_pin(12'd0);
    send_pin(12'd4095);
    send_pin(12'hAAA);
    send_pin(12'h555);
    wait_for_results(SETTLE);
    write_reg(REG_DIV_LEG, '0);
    send_pin(12'd123);
    wait_for_results(SETTLE);
    // top point with all ones: level saturates at the field limit
    write_reg(REG_CURVE_0, 32'hFFFF_FFFF);
    send_pin(12'd5);
    wait_for_results(SETTLE);
    load_divider(24'hFFFFFF, 24'd1);
    send_pin(12'd1);
    wait_for_results(SETTLE);
    load_divider(24'd1, 24'hFFFFFF);
    send_pin(12'd4095);
    wait_for_results(SETTLE);
  endtask

  // irregular curves at unit ratio so the pin value is the battery voltage
  task automatic test_curve_corners;
    load_divider(24'd1, 24'd1);
    // zero charge ahead of the last point, all-zero last point
    load_curve({16'd4000, 16'd10000, 16'd3000, 16'd5000, 16'd2000, 16'd0,
                16'd1500, 16'd3000, 16'd1000, 16'd2000, 32'd0});
    send_pin(12'd1800);
    send_pin(12'd2500);
    wait_for_results(SETTLE);
    // oversized top charge, rising charge, nonzero lowest charge
    load_curve({16'd4000, 16'hFFFF, 16'd3500, 16'd9001, 16'd2900, 16'd12000,
                16'd2500, 16'd20000, 16'd2000, 16'd100, 16'd1000, 16'd500});
    send_pin(12'd4095);
    send_pin(12'd3201);
    send_pin(12'd2600);
    send_pin(12'd1500);
    send_pin(12'd1000);
    send_pin(12'd999);
    wait_for_results(SETTLE);
  endtask

  // random divider and a falling curve spread over the reachable voltages
  task automatic load_random_setting;
    logic [PT_W*MAX_POINTS-1:0] pts;
    logic [OHM_W-1:0]           f;
    logic [OHM_W-1:0]           o;
    longint unsigned            fl;
    longint unsigned            span;
    longint unsigned            v;
    longint unsigned            drop;
    int                         p;
    int                         k;
    o  = OHM_W'($urandom_range(1, 300000));
    fl = longint'(o) * $urandom_range(1, 16) + $urandom_range(0, o - 1);
    f  = fl > 64'hFFFFFF ? 24'hFFFFFF : fl[OHM_W-1:0];
    if ($urandom_range(0, 7) == 0) begin
      f = OHM_W'($urandom);
      o = OHM_W'($urandom);
    end
    span = (o == '0) ? 64'd65535 : (64'd4095 * f) / o;
    if (span > 64'd65535) span = 64'd65535;
    v = $urandom_range(32'(span / 2), 32'(span + span / 8 + 1));
    if (v > 64'd65535) v = 64'd65535;
    p = $urandom_range(6000, 10000);
    for (k = 0; k < MAX_POINTS; k++) begin
      if (k == MAX_POINTS - 1) p = 0;
      pts[PT_W*(MAX_POINTS-1-k) +: PT_W] = {v[15:0], p[15:0]};
      // now and then a point word is pure noise
      if ($urandom_range(0, 9) == 0) pts[PT_W*(MAX_POINTS-1-k) +: PT_W] = $urandom;
      drop = $urandom_range(0, 32'(span / 4 + 1));
      v    = drop > v ? 64'd0 : v - drop;
      p    = p - $urandom_range(0, 3000);
      if (p < 0) p = 0;
    end
    load_divider(f, o);
    load_curve(pts);
    random_curves++;
  endtask

  task automatic send_random_pins(input int count);
    int j;
    for (j = 0; j < count; j++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_pin($urandom_range(0, 1) ? 12'd4095 : 12'd0);
      end else begin
        send_pin(PIN_W'($urandom));
      end
    end
  endtask

  task automatic test_random_curves(input int phases, input int per_phase);
    int ph;
    for (ph = 0; ph < phases; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      load_random_setting();
      send_random_pins(per_phase);
      wait_for_results(SETTLE);
    end
  endtask

  // receiver stalls for a long stretch while pin words keep coming
  task automatic test_output_backpressure;
    idle_on = 1'b0;
    load_random_setting();
    hold_requests++;
    send_random_pins(40);
    wait_for_results(SETTLE);
  endtask

  // closing stream with no gaps on either side
  task automatic test_steady_stream;
    idle_on = 1'b0;
    load_random_setting();
    send_random_pins(60);
    wait_for_results(END_WAIT);
  endtask

  // receiver: long hold on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_served < hold_requests) begin
      out_ready = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      hold_served++;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_ready = 1'b1;
    end
  end

  // compare each accepted charge word with the oldest expectation
  always @(posedge clk) begin : check_results
    charge_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (charge_expected.size() == 0) begin
        $error("unexpected charge word: battery_millivolts %0d level_pptt %0d",
               battery_millivolts, level_pptt);
        errors++;
      end else begin
        want = charge_expected.pop_front();
        words_checked++;
        if (battery_millivolts !== want.mv) begin
          $error("battery_millivolts: expected %0d, got %0d", want.mv, battery_millivolts);
          errors++;
        end
        if (level_pptt !== want.level) begin
          $error("level_pptt: expected %0d, got %0d", want.level, level_pptt);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    pin_millivolts = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    curve_pt       = CURVE_RESET;
    div_total      = DIV_TOTAL_RESET;
    div_leg        = DIV_LEG_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (SETTLE) @(negedge clk);

    test_reset_curve();
    test_divider_corners();
    test_curve_corners();
    test_random_curves(8, 66);
    test_output_backpressure();
    test_steady_stream();

    if (charge_expected.size() != 0) begin
      $error("%0d charge words never arrived", charge_expected.size());
      errors++;
    end
    $display("checked %0d charge words for %0d pin words after %0d register writes",
             words_checked, words_sent, cfg_writes);
    $display("covered reset curve, divider corners, odd curves, %0d random settings, long stall",
             random_curves);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
